FILE: src/bscf_pkg.sv
// Shared types, constants and CRC-32 byte update for the byte stuffing framer.
// Used by every module of the framer; depends on nothing.
package bscf_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam logic [31:0] CrcPoly = 32'hEDB88320;

  typedef enum logic [1:0] {
    RegStartCode  = 2'd0,
    RegEndCode    = 2'd1,
    RegEscapeCode = 2'd2,
    RegXorMask    = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       first_of_message;
    logic       last_of_message;
  } in_item_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_end;
  } out_item_t;

  typedef struct packed {
    logic [7:0] start_code;
    logic [7:0] end_code;
    logic [7:0] escape_code;
    logic [7:0] xor_mask;
  } codes_t;

  typedef struct packed {
    logic        start;
    logic [7:0]  payload;
    logic        last;
    logic [31:0] crc;
  } entry_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] r;
    r = crc_in ^ {24'h000000, data};
    for (int b = 0; b < 8; b++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

  localparam logic [31:0] CrcResidue =
    crc_byte(crc_byte(crc_byte(crc_byte(32'h00000000, 8'hFF), 8'hFF), 8'hFF), 8'hFF);

endpackage

FILE: src/bscf_front.sv
// Front end: accepts input items, runs the CRC-32 and builds queue entries.
// Depends on bscf_pkg.
module bscf_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bscf_pkg::in_item_t in_data_i,
  output logic               push_o,
  output bscf_pkg::entry_t   entry_o,
  input  logic               full_i
);
  import bscf_pkg::*;

  logic [31:0] crc_q, crc_d;
  logic [31:0] crc_base;
  logic [31:0] crc_new;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    crc_base      = in_data_i.first_of_message ? 32'hFFFFFFFF : crc_q;
    crc_new       = crc_byte(crc_base, in_data_i.payload_byte);
    entry_o.start   = in_data_i.first_of_message;
    entry_o.payload = in_data_i.payload_byte;
    entry_o.last    = in_data_i.last_of_message;
    entry_o.crc     = ~crc_new;
    crc_d = crc_q;
    if (push_o) begin
      crc_d = in_data_i.last_of_message ? CrcResidue : crc_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= 32'hFFFFFFFF;
    end else begin
      crc_q <= crc_d;
    end
  end

endmodule

FILE: src/bscf_fifo.sv
// Short queue of classified entries between front end and back end.
// Depends on bscf_pkg.
module bscf_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  bscf_pkg::entry_t wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output bscf_pkg::entry_t rdata_o
);
  import bscf_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  entry_t            mem_q [QueueDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

FILE: src/bscf_back.sv
// Back end: start code if first, stuffed byte, stuffed CRC and end code if last.
// Depends on bscf_pkg; drives the registered output channel.
module bscf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bscf_pkg::codes_t    codes_i,
  input  logic                q_valid_i,
  input  bscf_pkg::entry_t    q_data_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bscf_pkg::out_item_t out_data_o
);
  import bscf_pkg::*;

  typedef enum logic [1:0] {
    StStart,
    StData,
    StCrc,
    StEnd
  } step_e;

  step_e     step_q;
  logic      busy_q;
  logic      esc_q;
  logic [1:0] crc_idx_q;
  entry_t    entry_q;
  logic      out_valid_q;
  out_item_t out_data_q;

  logic [7:0] raw;
  logic       stuffable;
  logic       match;
  logic       need_esc;
  logic [7:0] byte_out;
  logic       done;
  logic       adv;

  always_comb begin
    unique case (step_q)
      StStart: raw = codes_i.start_code;
      StData:  raw = entry_q.payload;
      StCrc:   raw = entry_q.crc[{crc_idx_q, 3'b000} +: 8];
      StEnd:   raw = codes_i.end_code;
      default: raw = codes_i.end_code;
    endcase
    stuffable = (step_q == StData) || (step_q == StCrc);
    match     = (raw == codes_i.start_code) || (raw == codes_i.end_code) ||
                (raw == codes_i.escape_code);
    need_esc  = stuffable && match && !esc_q;
    if (need_esc) begin
      byte_out = codes_i.escape_code;
    end else if (esc_q) begin
      byte_out = raw ^ codes_i.xor_mask;
    end else begin
      byte_out = raw;
    end
    done  = !need_esc && (((step_q == StData) && !entry_q.last) || (step_q == StEnd));
    adv   = busy_q && (!out_valid_q || out_ready_i);
    pop_o = q_valid_i && (!busy_q || (adv && done));
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= StStart;
      busy_q      <= 1'b0;
      esc_q       <= 1'b0;
      crc_idx_q   <= '0;
      entry_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (adv) begin
        out_valid_q          <= 1'b1;
        out_data_q.line_byte <= byte_out;
        out_data_q.run_end   <= done;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      if (adv) begin
        if (need_esc) begin
          esc_q <= 1'b1;
        end else begin
          esc_q <= 1'b0;
          unique case (step_q)
            StStart: step_q <= StData;
            StData: begin
              if (entry_q.last) begin
                step_q    <= StCrc;
                crc_idx_q <= '0;
              end else begin
                busy_q <= 1'b0;
              end
            end
            StCrc: begin
              if (crc_idx_q == 2'd3) begin
                step_q <= StEnd;
              end else begin
                crc_idx_q <= crc_idx_q + 1'b1;
              end
            end
            StEnd:   busy_q <= 1'b0;
            default: busy_q <= 1'b0;
          endcase
        end
      end

      if (pop_o) begin
        entry_q   <= q_data_i;
        busy_q    <= 1'b1;
        esc_q     <= 1'b0;
        crc_idx_q <= '0;
        step_q    <= q_data_i.start ? StStart : StData;
      end
    end
  end

endmodule

FILE: src/byte_stuffing_crc32_framer.sv
// An accepted item goes through the queue and the back-end entry register before its first
// line byte reaches the registered output. Throughput: one line byte per cycle while the
// output is ready; an item produces 1 to 12 line bytes on the single output byte port.
// Input accepted every cycle while the two-entry queue has room.
// Reset: codes 0x00/0xFF/0xFE, mask 0x20, CRC preset to all ones, queue and output empty.
module byte_stuffing_crc32_framer (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  bscf_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output bscf_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [7:0]          cfg_data_i
);
  import bscf_pkg::*;

  codes_t codes_q;
  logic   push;
  logic   full;
  logic   pop;
  logic   q_valid;
  entry_t wr_entry;
  entry_t rd_entry;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codes_q.start_code  <= 8'h00;
      codes_q.end_code    <= 8'hFF;
      codes_q.escape_code <= 8'hFE;
      codes_q.xor_mask    <= 8'h20;
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        RegStartCode:  codes_q.start_code  <= cfg_data_i;
        RegEndCode:    codes_q.end_code    <= cfg_data_i;
        RegEscapeCode: codes_q.escape_code <= cfg_data_i;
        RegXorMask:    codes_q.xor_mask    <= cfg_data_i;
        default:       codes_q.xor_mask    <= codes_q.xor_mask;
      endcase
    end
  end

  bscf_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .entry_o    (wr_entry),
    .full_i     (full)
  );

  bscf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (wr_entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (rd_entry)
  );

  bscf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .codes_i     (codes_q),
    .q_valid_i   (q_valid),
    .q_data_i    (rd_entry),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
